// ----- rtl/one_wire_temperature_reader_top_macros.svh -----
// Assertion macros used by the checker file of the temperature reader.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ONE_WIRE_TEMPERATURE_READER_TOP_MACROS_SVH
`define ONE_WIRE_TEMPERATURE_READER_TOP_MACROS_SVH

// General property, checked on every rising edge outside reset.
`define OWTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// A result word that is stalled keeps the given field unchanged.
`define OWTR_ASSERT_HOLD(lbl, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    out_valid && out_stall |=> $stable(sig)) \
    else $error(msg);

`endif

// ----- rtl/owtr_pkg.sv -----
// Types, command bytes, register indexes and status codes of the temperature reader.
// Used by the sequencer, the top level and the checker; depends on nothing.
package owtr_pkg;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_RST_LOW  = 5'd1,
    PH_RST_WAIT = 5'd2,
    PH_RST_TAIL = 5'd3,
    PH_WR_START = 5'd4,
    PH_WR_HOLD  = 5'd5,
    PH_RD_START = 5'd6,
    PH_RD_WAIT  = 5'd7,
    PH_RD_TAIL  = 5'd8
  } phase_t;

  // Command step codes.
  localparam logic [2:0] STEP_SKIP1    = 3'd0;
  localparam logic [2:0] STEP_CONVERT  = 3'd1;
  localparam logic [2:0] STEP_POLL     = 3'd2;
  localparam logic [2:0] STEP_SKIP2    = 3'd3;
  localparam logic [2:0] STEP_READ_PAD = 3'd4;
  localparam logic [2:0] STEP_LOW      = 3'd5;
  localparam logic [2:0] STEP_HIGH     = 3'd6;

  localparam logic [7:0] CMD_SKIP     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_PAD = 8'hBE;

  localparam logic [2:0] LAST_BIT = 3'd7;
  localparam logic [15:0] POLL_MAX = 16'hFFFF;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PRES  = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_START_PULSE   = 3'd3;
  localparam logic [2:0] REG_WRITE_SLOT    = 3'd4;
  localparam logic [2:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [2:0] REG_READ_TAIL     = 3'd6;
  localparam logic [2:0] REG_POLL_LIMIT    = 3'd7;

  localparam logic [9:0]  RST_RESET_LOW     = 10'd480;
  localparam logic [9:0]  RST_PRESENCE_WAIT = 10'd60;
  localparam logic [9:0]  RST_RESET_TAIL    = 10'd420;
  localparam logic [9:0]  RST_START_PULSE   = 10'd1;
  localparam logic [9:0]  RST_WRITE_SLOT    = 10'd60;
  localparam logic [9:0]  RST_READ_SAMPLE   = 10'd14;
  localparam logic [9:0]  RST_READ_TAIL     = 10'd45;
  localparam logic [15:0] RST_POLL_LIMIT    = 16'hFFFF;

  localparam logic [20:0] TEMP_INT_SCALE  = 21'd10000;
  localparam logic [20:0] TEMP_FRAC_SCALE = 21'd625;

  typedef struct packed {
    logic [9:0]  reset_low_us;
    logic [9:0]  presence_wait_us;
    logic [9:0]  reset_tail_us;
    logic [9:0]  start_pulse_us;
    logic [9:0]  write_slot_us;
    logic [9:0]  read_sample_us;
    logic [9:0]  read_tail_us;
    logic [15:0] poll_limit;
  } cfg_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [20:0] temperature;
  } result_t;

  // Timer load value: a duration of zero acts as one tick.
  function automatic logic [9:0] dur_load(input logic [9:0] d);
    return (d == 10'd0) ? 10'd0 : d - 10'd1;
  endfunction

endpackage

// ----- rtl/one_wire_temperature_reader_top.sv -----
// A result word is in the output register in the cycle after its tick is taken.
// Throughput: one tick per cycle while no held word is stalled; the sequencer's single-pass next-state logic sets it.
// A new tick is taken while the previous word waits, unless that word is stalled.
// Reset (synchronous, active high) clears the sequencer to idle, empties the output
// register and loads the timing registers with their default values.
module one_wire_temperature_reader_top #(
  parameter int TIMER_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic        line_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        drive_low,
  output logic        busy_res,
  output logic        done_res,
  output logic [1:0]  status,
  output logic [20:0] temperature,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  owtr_pkg::cfg_t    cfg;
  owtr_pkg::result_t res;
  logic              in_accept, cfg_write;
  logic [2:0]        reg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us     <= owtr_pkg::RST_RESET_LOW;
      cfg.presence_wait_us <= owtr_pkg::RST_PRESENCE_WAIT;
      cfg.reset_tail_us    <= owtr_pkg::RST_RESET_TAIL;
      cfg.start_pulse_us   <= owtr_pkg::RST_START_PULSE;
      cfg.write_slot_us    <= owtr_pkg::RST_WRITE_SLOT;
      cfg.read_sample_us   <= owtr_pkg::RST_READ_SAMPLE;
      cfg.read_tail_us     <= owtr_pkg::RST_READ_TAIL;
      cfg.poll_limit       <= owtr_pkg::RST_POLL_LIMIT;
    end else if (cfg_write) begin
      case (reg_index)
        owtr_pkg::REG_RESET_LOW:     cfg.reset_low_us     <= pwdata[9:0];
        owtr_pkg::REG_PRESENCE_WAIT: cfg.presence_wait_us <= pwdata[9:0];
        owtr_pkg::REG_RESET_TAIL:    cfg.reset_tail_us    <= pwdata[9:0];
        owtr_pkg::REG_START_PULSE:   cfg.start_pulse_us   <= pwdata[9:0];
        owtr_pkg::REG_WRITE_SLOT:    cfg.write_slot_us    <= pwdata[9:0];
        owtr_pkg::REG_READ_SAMPLE:   cfg.read_sample_us   <= pwdata[9:0];
        owtr_pkg::REG_READ_TAIL:     cfg.read_tail_us     <= pwdata[9:0];
        default:                     cfg.poll_limit       <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      owtr_pkg::REG_RESET_LOW:     prdata = {22'd0, cfg.reset_low_us};
      owtr_pkg::REG_PRESENCE_WAIT: prdata = {22'd0, cfg.presence_wait_us};
      owtr_pkg::REG_RESET_TAIL:    prdata = {22'd0, cfg.reset_tail_us};
      owtr_pkg::REG_START_PULSE:   prdata = {22'd0, cfg.start_pulse_us};
      owtr_pkg::REG_WRITE_SLOT:    prdata = {22'd0, cfg.write_slot_us};
      owtr_pkg::REG_READ_SAMPLE:   prdata = {22'd0, cfg.read_sample_us};
      owtr_pkg::REG_READ_TAIL:     prdata = {22'd0, cfg.read_tail_us};
      default:                     prdata = {16'd0, cfg.poll_limit};
    endcase
  end

  // Only a word that is both present and stalled holds the input side back.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  owtr_seq #(
    .TIMER_BITS(TIMER_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (in_accept),
    .action     (action),
    .line_level (line_level),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      drive_low   <= res.drive_low;
      busy_res    <= res.busy;
      done_res    <= res.done;
      status      <= res.status;
      temperature <= res.temperature;
    end
  end

endmodule

// ----- rtl/owtr_seq.sv -----
// Bus sequencer of the temperature reader: phase state, microsecond timer,
// bit and byte shifting and the per-tick result. Depends on owtr_pkg.
module owtr_seq #(
  parameter int TIMER_BITS = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             action,
  input  logic             line_level,
  input  owtr_pkg::cfg_t   cfg,
  output owtr_pkg::result_t res
);

  owtr_pkg::phase_t        phase, phase_next, ph0;
  logic [TIMER_BITS-1:0]   us_timer, us_timer_next, tm0;
  logic [2:0]              bit_index, bit_index_next, bi0;
  logic [2:0]              command_step, command_step_next, cs0;
  logic [7:0]              shift_byte, shift_byte_next, sb0;
  logic [15:0]             poll_count, poll_count_next, pc0, pc_inc;
  logic [7:0]              low_byte, low_byte_next;
  logic [7:0]              high_byte, high_byte_next;
  logic                    start, last, fin;
  logic [1:0]              fin_status;
  logic [6:0]              int_part;

  // A start in idle turns this same tick into the first reset-low tick.
  assign start = (phase == owtr_pkg::PH_IDLE) && action;
  assign ph0 = start ? owtr_pkg::PH_RST_LOW : phase;
  assign tm0 = start ? TIMER_BITS'(owtr_pkg::dur_load(cfg.reset_low_us)) : us_timer;
  assign cs0 = start ? owtr_pkg::STEP_SKIP1 : command_step;
  assign pc0 = start ? 16'd0 : poll_count;
  assign bi0 = start ? 3'd0 : bit_index;
  assign sb0 = start ? 8'd0 : shift_byte;
  assign last = (tm0 == '0);
  assign pc_inc = (pc0 == owtr_pkg::POLL_MAX) ? pc0 : pc0 + 16'd1;

  always_comb begin
    phase_next        = ph0;
    us_timer_next     = last ? tm0 : tm0 - TIMER_BITS'(1);
    bit_index_next    = bi0;
    command_step_next = cs0;
    shift_byte_next   = sb0;
    poll_count_next   = pc0;
    low_byte_next     = low_byte;
    high_byte_next    = high_byte;
    fin               = 1'b0;
    fin_status        = owtr_pkg::ST_OK;
    case (ph0)
      owtr_pkg::PH_IDLE: begin
        us_timer_next = tm0;
      end
      owtr_pkg::PH_RST_LOW: begin
        if (last) begin
          phase_next    = owtr_pkg::PH_RST_WAIT;
          us_timer_next = TIMER_BITS'(owtr_pkg::dur_load(cfg.presence_wait_us));
        end
      end
      owtr_pkg::PH_RST_WAIT: begin
        if (last) begin
          if (line_level) begin
            fin        = 1'b1;
            fin_status = owtr_pkg::ST_NO_PRES;
          end else begin
            phase_next    = owtr_pkg::PH_RST_TAIL;
            us_timer_next = TIMER_BITS'(owtr_pkg::dur_load(cfg.reset_tail_us));
          end
        end
      end
      owtr_pkg::PH_RST_TAIL: begin
        if (last) begin
          shift_byte_next = owtr_pkg::CMD_SKIP;
          bit_index_next  = 3'd0;
          phase_next      = owtr_pkg::PH_WR_START;
          us_timer_next   = TIMER_BITS'(owtr_pkg::dur_load(cfg.start_pulse_us));
        end
      end
      owtr_pkg::PH_WR_START: begin
        if (last) begin
          phase_next    = owtr_pkg::PH_WR_HOLD;
          us_timer_next = TIMER_BITS'(owtr_pkg::dur_load(cfg.write_slot_us));
        end
      end
      owtr_pkg::PH_WR_HOLD: begin
        if (last) begin
          if (bi0 == owtr_pkg::LAST_BIT) begin
            // Byte written: move on to the next command of the sequence.
            case (cs0)
              owtr_pkg::STEP_SKIP1: begin
                command_step_next = owtr_pkg::STEP_CONVERT;
                shift_byte_next   = owtr_pkg::CMD_CONVERT;
                bit_index_next    = 3'd0;
                phase_next        = owtr_pkg::PH_WR_START;
              end
              owtr_pkg::STEP_CONVERT: begin
                command_step_next = owtr_pkg::STEP_POLL;
                poll_count_next   = 16'd0;
                shift_byte_next   = 8'd0;
                phase_next        = owtr_pkg::PH_RD_START;
              end
              owtr_pkg::STEP_SKIP2: begin
                command_step_next = owtr_pkg::STEP_READ_PAD;
                shift_byte_next   = owtr_pkg::CMD_READ_PAD;
                bit_index_next    = 3'd0;
                phase_next        = owtr_pkg::PH_WR_START;
              end
              default: begin
                command_step_next = owtr_pkg::STEP_LOW;
                bit_index_next    = 3'd0;
                shift_byte_next   = 8'd0;
                phase_next        = owtr_pkg::PH_RD_START;
              end
            endcase
          end else begin
            bit_index_next  = bi0 + 3'd1;
            shift_byte_next = {1'b0, sb0[7:1]};
            phase_next      = owtr_pkg::PH_WR_START;
          end
          us_timer_next = TIMER_BITS'(owtr_pkg::dur_load(cfg.start_pulse_us));
        end
      end
      owtr_pkg::PH_RD_START: begin
        if (last) begin
          phase_next    = owtr_pkg::PH_RD_WAIT;
          us_timer_next = TIMER_BITS'(owtr_pkg::dur_load(cfg.read_sample_us));
        end
      end
      owtr_pkg::PH_RD_WAIT: begin
        if (last) begin
          if (cs0 == owtr_pkg::STEP_POLL) begin
            shift_byte_next = {7'd0, line_level};
          end else begin
            shift_byte_next = {line_level, sb0[7:1]};
          end
          phase_next    = owtr_pkg::PH_RD_TAIL;
          us_timer_next = TIMER_BITS'(owtr_pkg::dur_load(cfg.read_tail_us));
        end
      end
      owtr_pkg::PH_RD_TAIL: begin
        if (last) begin
          phase_next    = owtr_pkg::PH_RD_START;
          us_timer_next = TIMER_BITS'(owtr_pkg::dur_load(cfg.start_pulse_us));
          if (cs0 == owtr_pkg::STEP_POLL) begin
            if (sb0[0]) begin
              command_step_next = owtr_pkg::STEP_SKIP2;
              phase_next        = owtr_pkg::PH_RST_LOW;
              us_timer_next     = TIMER_BITS'(owtr_pkg::dur_load(cfg.reset_low_us));
            end else begin
              poll_count_next = pc_inc;
              if (pc_inc >= cfg.poll_limit) begin
                fin        = 1'b1;
                fin_status = owtr_pkg::ST_TIMEOUT;
              end
            end
          end else if (bi0 == owtr_pkg::LAST_BIT) begin
            if (cs0 == owtr_pkg::STEP_LOW) begin
              low_byte_next     = sb0;
              command_step_next = owtr_pkg::STEP_HIGH;
              bit_index_next    = 3'd0;
              shift_byte_next   = 8'd0;
            end else begin
              high_byte_next = sb0;
              fin            = 1'b1;
              fin_status     = owtr_pkg::ST_OK;
            end
          end else begin
            bit_index_next = bi0 + 3'd1;
          end
        end
      end
      default: begin
        phase_next    = owtr_pkg::PH_IDLE;
        us_timer_next = '0;
      end
    endcase
    if (fin) begin
      phase_next    = owtr_pkg::PH_IDLE;
      us_timer_next = '0;
    end
  end

  assign int_part = {high_byte_next[2:0], low_byte_next[7:4]};

  always_comb begin
    res.drive_low   = 1'b0;
    res.busy        = 1'b0;
    res.done        = fin;
    res.status      = fin ? fin_status : owtr_pkg::ST_OK;
    res.temperature = 21'd0;
    case (ph0)
      owtr_pkg::PH_RST_LOW, owtr_pkg::PH_WR_START, owtr_pkg::PH_RD_START: begin
        res.drive_low = 1'b1;
        res.busy      = 1'b1;
      end
      owtr_pkg::PH_WR_HOLD: begin
        res.drive_low = ~sb0[0];
        res.busy      = 1'b1;
      end
      owtr_pkg::PH_RST_WAIT, owtr_pkg::PH_RST_TAIL, owtr_pkg::PH_RD_WAIT,
      owtr_pkg::PH_RD_TAIL: begin
        res.busy = ~fin;
      end
      default: begin
        res.busy = 1'b0;
      end
    endcase
    if (fin && (fin_status == owtr_pkg::ST_OK)) begin
      res.temperature = 21'(int_part) * owtr_pkg::TEMP_INT_SCALE
                      + 21'(low_byte_next[3:0]) * owtr_pkg::TEMP_FRAC_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= owtr_pkg::PH_IDLE;
      us_timer     <= '0;
      bit_index    <= 3'd0;
      command_step <= owtr_pkg::STEP_SKIP1;
      shift_byte   <= 8'd0;
      poll_count   <= 16'd0;
      low_byte     <= 8'd0;
      high_byte    <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      us_timer     <= us_timer_next;
      bit_index    <= bit_index_next;
      command_step <= command_step_next;
      shift_byte   <= shift_byte_next;
      poll_count   <= poll_count_next;
      low_byte     <= low_byte_next;
      high_byte    <= high_byte_next;
    end
  end

endmodule

// ----- rtl/owtr_checker.sv -----
// Port-level checks of the temperature reader, bound to the top level.
// Depends on owtr_pkg and one_wire_temperature_reader_top_macros.svh.
`include "one_wire_temperature_reader_top_macros.svh"

module owtr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        busy_res,
  input logic        done_res,
  input logic [1:0]  status,
  input logic [20:0] temperature
);

  // The input side only waits behind a result word that is really there.
  `OWTR_ASSERT(a_stall_has_word, in_stall |-> out_valid, "input stalled with no word held")

  // The finishing tick never reports busy.
  `OWTR_ASSERT(a_done_not_busy, out_valid && done_res |-> !busy_res, "done word marked busy")

  // Status and temperature stay zero on every word that does not finish a read.
  `OWTR_ASSERT(a_quiet_unless_done, out_valid && !done_res |-> (status == owtr_pkg::ST_OK) && (temperature == 21'd0), "status or temperature set without done")

  `OWTR_ASSERT_HOLD(a_hold_temperature, temperature, "stalled temperature changed")

endmodule

bind one_wire_temperature_reader_top owtr_checker u_owtr_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for one_wire_temperature_reader_top: drives microsecond ticks
// from a simple sensor model and checks every result word against an in-bench predictor.
// Depends on owtr_pkg and the top level of the reader.
module testbench;
  import owtr_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int QUIET_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        action = 1'b0;
  logic        line_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic [1:0]  status;
  logic [20:0] temperature;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  one_wire_temperature_reader_top dut (.*);

  always #6 clk = ~clk;

  // Predictor state and its copy of the timing registers.
  phase_t      ph;
  logic [9:0]  tmr;
  logic [2:0]  bit_idx;
  logic [2:0]  cmd_step;
  logic [7:0]  shreg;
  logic [15:0] polls;
  logic [7:0]  lo_b;
  logic [7:0]  hi_b;
  logic [15:0] regs [8];

  result_t predicted_words[$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      sender_idle_pct = 0;
  int      receiver_idle_pct = 0;
  int      holds_asked = 0;
  int      holds_served = 0;
  int      hold_left = 0;

  // What the simulated sensor answers during the current read.
  bit          present_first;
  bit          present_second;
  int          fails_before_ready;
  logic [7:0]  sensor_low;
  logic [7:0]  sensor_high;
  int          glitch_pct;

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      // Keep the log short when a run goes badly wrong.
      if (mismatch_count <= 100)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  function automatic void start_phase(input phase_t p, input logic [15:0] d);
    logic [9:0] dd;
    dd = (d[9:0] == 10'd0) ? 10'd1 : d[9:0];
    ph = p;
    tmr = dd - 10'd1;
  endfunction

  function automatic void load_byte(input logic [7:0] b);
    shreg = b;
    bit_idx = '0;
    start_phase(PH_WR_START, regs[REG_START_PULSE]);
  endfunction

  function automatic void conclude(input logic [1:0] st, inout result_t r);
    ph = PH_IDLE;
    tmr = '0;
    r.busy = 1'b0;
    r.done = 1'b1;
    r.status = st;
    if (st == ST_OK)
      r.temperature = 21'({hi_b[2:0], lo_b[7:4]}) * 21'd10000 + 21'(lo_b[3:0]) * 21'd625;
  endfunction

  // Advances the predicted sequencer by one tick and returns the word it should produce.
  function automatic result_t step_sequencer(input logic act, input logic lvl);
    result_t r;
    logic    last;
    r = '0;
    if (ph == PH_IDLE && act) begin
      cmd_step = STEP_SKIP1;
      polls = '0;
      bit_idx = '0;
      shreg = '0;
      start_phase(PH_RST_LOW, regs[REG_RESET_LOW]);
    end
    if (ph != PH_IDLE) begin
      r.busy = 1'b1;
      r.drive_low = (ph == PH_RST_LOW || ph == PH_WR_START || ph == PH_RD_START ||
                     (ph == PH_WR_HOLD && !shreg[0]));
      last = (tmr == 10'd0);
      if (!last)
        tmr = tmr - 10'd1;
      case (ph)
        PH_RST_LOW: if (last) start_phase(PH_RST_WAIT, regs[REG_PRESENCE_WAIT]);
        PH_RST_WAIT: if (last) begin
          if (lvl)
            conclude(ST_NO_PRES, r);
          else
            start_phase(PH_RST_TAIL, regs[REG_RESET_TAIL]);
        end
        PH_RST_TAIL: if (last) load_byte(CMD_SKIP);
        PH_WR_START: if (last) start_phase(PH_WR_HOLD, regs[REG_WRITE_SLOT]);
        PH_WR_HOLD: if (last) begin
          if (bit_idx >= LAST_BIT) begin
            case (cmd_step)
              STEP_SKIP1: begin
                cmd_step = STEP_CONVERT;
                load_byte(CMD_CONVERT);
              end
              STEP_CONVERT: begin
                cmd_step = STEP_POLL;
                polls = '0;
                shreg = '0;
                start_phase(PH_RD_START, regs[REG_START_PULSE]);
              end
              STEP_SKIP2: begin
                cmd_step = STEP_READ_PAD;
                load_byte(CMD_READ_PAD);
              end
              default: begin
                cmd_step = STEP_LOW;
                bit_idx = '0;
                shreg = '0;
                start_phase(PH_RD_START, regs[REG_START_PULSE]);
              end
            endcase
          end else begin
            bit_idx = bit_idx + 3'd1;
            shreg = shreg >> 1;
            start_phase(PH_WR_START, regs[REG_START_PULSE]);
          end
        end
        PH_RD_START: if (last) start_phase(PH_RD_WAIT, regs[REG_READ_SAMPLE]);
        PH_RD_WAIT: if (last) begin
          // A poll keeps only the bit just read; data bits shift in from the top.
          if (cmd_step == STEP_POLL)
            shreg = {7'd0, lvl};
          else
            shreg = {lvl, shreg[7:1]};
          start_phase(PH_RD_TAIL, regs[REG_READ_TAIL]);
        end
        PH_RD_TAIL: if (last) begin
          if (cmd_step == STEP_POLL) begin
            if (shreg[0]) begin
              cmd_step = STEP_SKIP2;
              start_phase(PH_RST_LOW, regs[REG_RESET_LOW]);
            end else begin
              if (polls < POLL_MAX)
                polls = polls + 16'd1;
              if (polls >= regs[REG_POLL_LIMIT])
                conclude(ST_TIMEOUT, r);
              else
                start_phase(PH_RD_START, regs[REG_START_PULSE]);
            end
          end else if (bit_idx >= LAST_BIT) begin
            if (cmd_step == STEP_LOW) begin
              lo_b = shreg;
              cmd_step = STEP_HIGH;
              bit_idx = '0;
              shreg = '0;
              start_phase(PH_RD_START, regs[REG_START_PULSE]);
            end else begin
              hi_b = shreg;
              conclude(ST_OK, r);
            end
          end else begin
            bit_idx = bit_idx + 3'd1;
            start_phase(PH_RD_START, regs[REG_START_PULSE]);
          end
        end
        default: begin
          ph = PH_IDLE;
          tmr = '0;
          r.busy = 1'b0;
          r.drive_low = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  // Line level the sensor shows on the next tick; only the sample ticks matter.
  function automatic logic sensor_line();
    if ($urandom_range(99) < glitch_pct)
      return 1'($urandom_range(1));
    if (tmr == 10'd0 && ph == PH_RST_WAIT)
      return (cmd_step == STEP_SKIP1) ? !present_first : !present_second;
    if (tmr == 10'd0 && ph == PH_RD_WAIT) begin
      if (cmd_step == STEP_POLL)
        return polls >= fails_before_ready;
      return (cmd_step == STEP_LOW) ? sensor_low[bit_idx] : sensor_high[bit_idx];
    end
    return 1'($urandom_range(1));
  endfunction

  task automatic send_tick(input logic act, input logic lvl);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    line_level <= lvl;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predicted_words.push_back(step_sequencer(act, lvl));
    items_sent++;
  endtask

  // One temperature read from start to finish, then a few ticks while idle.
  task automatic run_read(input bit pres1, input bit pres2, input int fails,
                          input logic [7:0] lo, input logic [7:0] hi, input int glitch);
    present_first = pres1;
    present_second = pres2;
    fails_before_ready = fails;
    sensor_low = lo;
    sensor_high = hi;
    glitch_pct = glitch;
    send_tick(1'b1, 1'($urandom_range(1)));
    while (ph != PH_IDLE)
      send_tick($urandom_range(15) == 0, sensor_line());
    repeat ($urandom_range(2))
      send_tick(1'b0, 1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (predicted_words.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    regs[idx] = (idx == REG_POLL_LIMIT) ? value : {6'd0, value[9:0]};
    @(posedge clk);
  endtask

  task automatic check_registers();
    for (int i = 0; i < 8; i++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {3'(i), 2'b00};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready)
        @(posedge clk);
      check_field($sformatf("register %0d", i), 32'(regs[i]), prdata);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic load_timing(input int rl, input int pw, input int rt, input int sp,
                             input int ws, input int rs, input int rtl, input int pl);
    drain();
    write_register(REG_RESET_LOW, 16'(rl));
    write_register(REG_PRESENCE_WAIT, 16'(pw));
    write_register(REG_RESET_TAIL, 16'(rt));
    write_register(REG_START_PULSE, 16'(sp));
    write_register(REG_WRITE_SLOT, 16'(ws));
    write_register(REG_READ_SAMPLE, 16'(rs));
    write_register(REG_READ_TAIL, 16'(rtl));
    write_register(REG_POLL_LIMIT, 16'(pl));
    check_registers();
  endtask

  task automatic test_register_reset_values();
    check_registers();
  endtask

  task automatic test_missing_presence_at_defaults();
    run_read(1'b0, 1'b1, 0, 8'h00, 8'h00, 0);
  endtask

  task automatic test_fast_reads();
    load_timing(1, 1, 1, 1, 1, 1, 1, 4);
    run_read(1'b1, 1'b1, 2, 8'hFF, 8'hFF, 0);
    run_read(1'b1, 1'b1, 3, 8'h5A, 8'hF8, 0);
  endtask

  task automatic test_poll_timeout();
    load_timing(2, 1, 2, 1, 2, 1, 2, 3);
    run_read(1'b1, 1'b1, 3, 8'h12, 8'h03, 0);
    load_timing(2, 1, 2, 1, 2, 1, 2, 0);
    run_read(1'b1, 1'b1, 1, 8'h33, 8'h01, 0);
    load_timing(1, 2, 1, 2, 1, 2, 1, 1);
    run_read(1'b1, 1'b1, 5, 8'h80, 8'h02, 0);
  endtask

  task automatic test_second_presence_missing();
    run_read(1'b1, 1'b0, 0, 8'h44, 8'h04, 0);
  endtask

  // A duration of zero behaves as one tick.
  task automatic test_zero_durations();
    load_timing(0, 0, 0, 0, 0, 0, 0, 0);
    run_read(1'b1, 1'b1, 0, 8'hC3, 8'h06, 0);
  endtask

  // Every register holds and reads back its widest value.
  task automatic test_longest_durations();
    load_timing(1023, 1023, 1023, 1023, 1023, 1023, 1023, 65535);
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_hold();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    load_timing(1, 1, 1, 1, 1, 1, 1, 2);
    holds_asked++;
    run_read(1'b1, 1'b1, 1, 8'h9C, 8'h01, 0);
  endtask

  task automatic test_random_reads(input int send_pct, input int recv_pct, input int quota);
    int first_item;
    int kind;
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    first_item = items_sent;
    while (items_sent - first_item < quota) begin
      if ($urandom_range(2) == 0)
        load_timing($urandom_range(3), $urandom_range(3), $urandom_range(3),
                    $urandom_range(2), $urandom_range(2), $urandom_range(2),
                    $urandom_range(2), $urandom_range(6));
      kind = $urandom_range(99);
      if (kind < 65)
        run_read(1'b1, 1'b1, $urandom_range(5), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 0);
      else if (kind < 75)
        run_read(1'b0, 1'b1, 0, 8'h00, 8'h00, 0);
      else if (kind < 85)
        run_read(1'b1, 1'b0, $urandom_range(3), 8'h00, 8'h00, 0);
      else
        run_read(1'b1, 1'b1, $urandom_range(5), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 30);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_words.size() == 0) begin
        mismatch_count++;
        $error("result word arrived with none expected");
      end else begin
        want = predicted_words.pop_front();
        check_field("drive_low", 32'(want.drive_low), 32'(drive_low));
        check_field("busy_res", 32'(want.busy), 32'(busy_res));
        check_field("done_res", 32'(want.done), 32'(done_res));
        check_field("status", 32'(want.status), 32'(status));
        check_field("temperature", 32'(want.temperature), 32'(temperature));
      end
    end
  end

  // Ends the run when neither side has moved a word for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < 8; i++)
      regs[i] = '0;
    regs[REG_RESET_LOW] = 16'(RST_RESET_LOW);
    regs[REG_PRESENCE_WAIT] = 16'(RST_PRESENCE_WAIT);
    regs[REG_RESET_TAIL] = 16'(RST_RESET_TAIL);
    regs[REG_START_PULSE] = 16'(RST_START_PULSE);
    regs[REG_WRITE_SLOT] = 16'(RST_WRITE_SLOT);
    regs[REG_READ_SAMPLE] = 16'(RST_READ_SAMPLE);
    regs[REG_READ_TAIL] = 16'(RST_READ_TAIL);
    regs[REG_POLL_LIMIT] = RST_POLL_LIMIT;
    ph = PH_IDLE;
    tmr = '0;
    bit_idx = '0;
    cmd_step = STEP_SKIP1;
    shreg = '0;
    polls = '0;
    lo_b = '0;
    hi_b = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_idle_pct = 28;
    receiver_idle_pct = 59;
    test_register_reset_values();
    test_missing_presence_at_defaults();
    test_fast_reads();
    test_poll_timeout();
    test_second_presence_missing();
    test_zero_durations();
    test_longest_durations();
    test_output_hold();
    test_random_reads(28, 59, 50);
    test_random_reads(59, 28, 50);
    test_random_reads(0, 0, 50);
    drain();
    if (mismatch_count == 0 && predicted_words.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- one_wire_temperature_reader_top.f -----
+incdir+rtl
rtl/owtr_pkg.sv
rtl/owtr_seq.sv
rtl/one_wire_temperature_reader_top.sv
rtl/owtr_checker.sv
dv/testbench.sv
